FILE: rtl/acss_pkg.sv
// Package for the ADC channel scan sequencer: command codes, widths,
// beat layouts and the channel list helpers. No dependencies.
`timescale 1ns / 1ps

package acss_pkg;

  localparam int unsigned NUM_VALUES   = 16;
  localparam int unsigned MAX_LIST     = 15;
  localparam int unsigned LIST_W       = 60;
  localparam int unsigned COUNT_W      = 4;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned RCH_W        = 8;
  localparam int unsigned RDATA_W      = 11;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = LIST_W;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned M_TDATA_W    = 24;
  localparam int unsigned TBL_IDX_W    = $clog2(NUM_VALUES);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_DONE  = 3'd1,
    CMD_READ  = 3'd2,
    CMD_START = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_LIST  = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_e;

  // Result beat, lowest bit last in the list.
  typedef struct packed {
    logic [6:0]                pad;
    logic                      scan_done;
    logic signed [RDATA_W-1:0] read_data;
    logic [CHAN_W-1:0]         conv_channel;
    logic                      conv_start;
  } result_t;

  localparam logic signed [RDATA_W-1:0] RDATA_OUT_OF_RANGE = '1;

  // Entry k of the channel list; the sixteenth slot does not exist and reads 0.
  function automatic logic [CHAN_W-1:0] list_entry(input logic [LIST_W-1:0] list,
                                                   input logic [CHAN_W-1:0] k);
    logic [5:0] sh;
    sh = {k, 2'b00};
    if (k == CHAN_W'(MAX_LIST)) begin
      list_entry = '0;
    end else begin
      list_entry = list[sh +: CHAN_W];
    end
  endfunction

  // Count of list entries in one scan: zero acts as one, saturate at the list size.
  function automatic logic [COUNT_W-1:0] used_count(input logic [COUNT_W-1:0] count);
    used_count = count;
    if (count == '0) begin
      used_count = COUNT_W'(1);
    end else if (32'(count) > MAX_LIST) begin
      used_count = COUNT_W'(MAX_LIST);
    end
  endfunction

endpackage

FILE: rtl/adc_channel_scan_sequencer.sv
// Top level of the ADC channel scan sequencer: command stream in, one result
// beat out per command. Depends on acss_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_axis_*): one command beat. tuser carries cmd (tick, conversion
//   done, read, start, stop); tdata carries sample and read_channel.
//   Master stream (m_axis_*): exactly one result beat per command beat, in order:
//   conv_start/conv_channel ask the converter for the next channel, scan_done
//   flags the end of a scan, read_data answers a read (-1 for a channel outside
//   the 16-entry value table).
//   Config channel (cfg_*): always ready; index 0 writes the 60-bit channel list,
//   index 1 writes the channel count. Write only while no command is in flight.
//   Latency: an accepted command beat passes through two register stages, input
//   then result, before its result beat is offered to the sink.
//   Throughput: one command per cycle while m_axis_tready stays high, set by the
//   single state update done between the input register and the result register.
//   Reset: disarms, clears the scan index, the in-flight flag, the value table
//   and both pipeline stages; channel list resets to 0, channel count to 1.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register fills behind it, and s_axis_tready drops until the sink drains.
module adc_channel_scan_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] sample, [17:10] read_channel, [23:18] zero
  input  logic [acss_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] cmd
  input  logic [acss_pkg::CMD_W-1:0]          s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] conv_start, [4:1] conv_channel, [15:5] read_data, [16] scan_done, [23:17] zero
  output logic [acss_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [acss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [acss_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [acss_pkg::LIST_W-1:0]  list_q;
  logic [acss_pkg::COUNT_W-1:0] count_q;

  // input register
  logic                           in_valid_q;
  logic [acss_pkg::CMD_W-1:0]     cmd_q;
  logic [acss_pkg::SAMPLE_W-1:0]  sample_q;
  logic [acss_pkg::RCH_W-1:0]     rch_q;

  // sequencer state
  logic                           armed_q, armed_d;
  logic                           flight_q, flight_d;
  logic [acss_pkg::CHAN_W-1:0]    idx_q, idx_d;
  logic [acss_pkg::SAMPLE_W-1:0]  table_q [acss_pkg::NUM_VALUES];
  logic                           tbl_we;
  logic [acss_pkg::TBL_IDX_W-1:0] tbl_waddr;

  // result register
  logic                           out_valid_q;
  acss_pkg::result_t              out_q, out_d;

  logic fire;      // input register hands its beat to the result register
  logic out_free;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_q  <= '0;
      count_q <= acss_pkg::COUNT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        acss_pkg::REG_CHANNEL_LIST:  list_q  <= cfg_data_i;
        acss_pkg::REG_CHANNEL_COUNT: count_q <= cfg_data_i[acss_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: load whenever the slot is free or drains this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q    <= s_axis_tuser;
      sample_q <= s_axis_tdata[acss_pkg::SAMPLE_W-1:0];
      rch_q    <= s_axis_tdata[acss_pkg::SAMPLE_W +: acss_pkg::RCH_W];
    end
  end

  // Command decode: next state, table write and result beat.
  always_comb begin
    logic [acss_pkg::CHAN_W-1:0] next_idx;
    logic [acss_pkg::CHAN_W-1:0] cur_ch;
    armed_d   = armed_q;
    flight_d  = flight_q;
    idx_d     = idx_q;
    tbl_we    = 1'b0;
    cur_ch    = acss_pkg::list_entry(list_q, idx_q);
    tbl_waddr = cur_ch[acss_pkg::TBL_IDX_W-1:0];
    next_idx  = idx_q + acss_pkg::CHAN_W'(1);
    out_d     = '0;
    case (cmd_q)
      acss_pkg::CMD_TICK: begin
        if (armed_q && !flight_q) begin
          idx_d              = '0;
          flight_d           = 1'b1;
          out_d.conv_start   = 1'b1;
          out_d.conv_channel = acss_pkg::list_entry(list_q, '0);
        end
      end
      acss_pkg::CMD_DONE: begin
        if (flight_q) begin
          // drop the sample when the listed channel lies outside the table
          tbl_we = (32'(cur_ch) < acss_pkg::NUM_VALUES);
          if (next_idx >= acss_pkg::used_count(count_q)) begin
            idx_d           = '0;
            flight_d        = 1'b0;
            out_d.scan_done = 1'b1;
          end else begin
            idx_d              = next_idx;
            out_d.conv_start   = 1'b1;
            out_d.conv_channel = acss_pkg::list_entry(list_q, next_idx);
          end
        end
      end
      acss_pkg::CMD_READ: begin
        if (32'(rch_q) >= acss_pkg::NUM_VALUES) begin
          out_d.read_data = acss_pkg::RDATA_OUT_OF_RANGE;
        end else begin
          out_d.read_data = {1'b0, table_q[rch_q[acss_pkg::TBL_IDX_W-1:0]]};
        end
      end
      acss_pkg::CMD_START: begin
        idx_d              = '0;
        armed_d            = 1'b1;
        flight_d           = 1'b1;
        out_d.conv_start   = 1'b1;
        out_d.conv_channel = acss_pkg::list_entry(list_q, '0);
      end
      acss_pkg::CMD_STOP: begin
        armed_d  = 1'b0;
        flight_d = 1'b0;
        idx_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      flight_q <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < acss_pkg::NUM_VALUES; i++) begin
        table_q[i] <= '0;
      end
    end else if (fire) begin
      armed_q  <= armed_d;
      flight_q <= flight_d;
      idx_q    <= idx_d;
      if (tbl_we) begin
        table_q[tbl_waddr] <= sample_q;
      end
    end
  end

  // Result stage: hold while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/acss_checker.sv
// Port-level checker for the ADC channel scan sequencer, bound to the top level.
// Depends on acss_pkg.
`timescale 1ns / 1ps

module acss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [acss_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  acss_pkg::result_t res;
  assign res = m_axis_tdata;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // completing a scan never also requests a conversion
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.scan_done && res.conv_start))
    else $error("scan_done with conv_start");

  // channel is zero unless a conversion is requested
  a_chan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.conv_start |-> res.conv_channel == '0)
    else $error("conv_channel set without conv_start");

  // read data is zero on conversion and scan-done beats, else a 10-bit value or the out-of-range marker
  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.conv_start || res.scan_done) |-> res.read_data == '0)
    else $error("read_data on a scan beat");

  a_rdata_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !res.read_data[acss_pkg::RDATA_W-1] ||
                      res.read_data == acss_pkg::RDATA_OUT_OF_RANGE)
    else $error("read_data out of range");

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
